@@ src/mmrpl_pkg.sv @@
// Shared widths, codes and controller/datapath interface types for the
// peak locator of a Merkle mountain range record store. No dependencies.
package mmrpl_pkg;

    localparam int LEAF_BITS = 48;
    localparam int POS_W     = LEAF_BITS + 1;
    localparam int HEIGHT_W  = 6;
    localparam int ONES_W    = $clog2(LEAF_BITS + 1);
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int MDATA_W   = ((2 * LEAF_BITS + HEIGHT_W + POS_W + 7) / 8) * 8;
    localparam int MPAD_W    = MDATA_W - (2 * LEAF_BITS + HEIGHT_W + POS_W);

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_PEAKS    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LEAF_POS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOTAL    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

    // What the output register is loaded with in a given cycle.
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ERR,
        EMIT_PEAK,
        EMIT_FINAL
    } emit_t;

    typedef struct packed {
        logic    load;
        logic    step;
        emit_t   emit;
        status_t err_status;
    } dp_cmd_t;

    typedef struct packed {
        logic in_invalid;
        logic in_empty;
        logic is_peaks;
        logic rest_msb;
        logic rest_tail_zero;
        logic rest_zero;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/mmrpl_ctrl.sv @@
// Controller state machine of the peak locator. Sequences the bit scan of
// the datapath and decides what result is emitted. Uses mmrpl_pkg.
module mmrpl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mmrpl_pkg::dp_status_t st,
    output mmrpl_pkg::dp_cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.emit       = mmrpl_pkg::EMIT_NONE;
        cmd.err_status = mmrpl_pkg::ST_INVALID;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = st.out_free;
                if (s_tvalid && st.out_free) begin
                    if (st.in_invalid) begin
                        cmd.emit       = mmrpl_pkg::EMIT_ERR;
                        cmd.err_status = mmrpl_pkg::ST_INVALID;
                    end else if (st.in_empty) begin
                        cmd.emit       = mmrpl_pkg::EMIT_ERR;
                        cmd.err_status = mmrpl_pkg::ST_EMPTY;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (st.out_free) begin
                    if (st.is_peaks) begin
                        cmd.step = 1'b1;
                        if (st.rest_msb) begin
                            cmd.emit = mmrpl_pkg::EMIT_PEAK;
                            if (st.rest_tail_zero) begin
                                state_next = S_IDLE;
                            end
                        end
                    end else if (st.rest_zero) begin
                        cmd.emit   = mmrpl_pkg::EMIT_FINAL;
                        state_next = S_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/mmrpl_dp.sv @@
// Datapath of the peak locator: request classification, the top-down bit
// scan registers and the result register. Uses mmrpl_pkg.
module mmrpl_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [mmrpl_pkg::CMD_W-1:0]            in_cmd,
    input  logic [mmrpl_pkg::LEAF_BITS-1:0]        in_query,
    input  logic [mmrpl_pkg::LEAF_BITS-1:0]        committed,
    input  mmrpl_pkg::dp_cmd_t                     cmd,
    output mmrpl_pkg::dp_status_t                  st,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mmrpl_pkg::STATUS_W-1:0]         out_status,
    output logic [mmrpl_pkg::LEAF_BITS-1:0]        out_first,
    output logic [mmrpl_pkg::LEAF_BITS-1:0]        out_count,
    output logic [mmrpl_pkg::HEIGHT_W-1:0]         out_height,
    output logic [mmrpl_pkg::POS_W-1:0]            out_pos,
    output logic                                   out_last
);

    localparam int LB = mmrpl_pkg::LEAF_BITS;

    logic [mmrpl_pkg::CMD_W-1:0]    cmd_reg;
    logic [LB-1:0]                  query_reg;
    logic [LB-1:0]                  rest_reg;
    logic [LB-1:0]                  cnt_reg;
    logic [LB-1:0]                  start_reg;
    logic [mmrpl_pkg::HEIGHT_W-1:0] h_reg;
    logic [mmrpl_pkg::ONES_W-1:0]   ones_reg;

    logic                           valid_reg;
    logic [mmrpl_pkg::STATUS_W-1:0] status_reg;
    logic [LB-1:0]                  first_reg;
    logic [LB-1:0]                  count_reg;
    logic [mmrpl_pkg::HEIGHT_W-1:0] height_reg;
    logic [mmrpl_pkg::POS_W-1:0]    pos_reg;
    logic                           last_reg;

    logic [LB-1:0]                  last_leaf;
    logic [mmrpl_pkg::POS_W-1:0]    peak_pos;
    logic [mmrpl_pkg::POS_W-1:0]    query_pos;

    // The last leaf of a peak is start | (cnt - 1); its ones are those of
    // start (one per peak already emitted) plus the height, so the height
    // cancels out of the record position.
    assign last_leaf = start_reg | (cnt_reg - LB'(1));
    assign peak_pos  = {last_leaf, 1'b0} - mmrpl_pkg::POS_W'(ones_reg);
    assign query_pos = {query_reg, 1'b0} - mmrpl_pkg::POS_W'(ones_reg);

    always_comb begin
        st.in_invalid = 1'b0;
        case (in_cmd)
            mmrpl_pkg::CMD_PEAKS:    st.in_invalid = in_query > committed;
            mmrpl_pkg::CMD_LEAF_POS: st.in_invalid = in_query >= committed;
            mmrpl_pkg::CMD_TOTAL:    st.in_invalid = in_query > committed;
            default:                 st.in_invalid = 1'b1;
        endcase
        st.in_empty       = (in_cmd == mmrpl_pkg::CMD_PEAKS) && (in_query == '0);
        st.is_peaks       = cmd_reg == mmrpl_pkg::CMD_PEAKS;
        st.rest_msb       = rest_reg[LB-1];
        st.rest_tail_zero = rest_reg[LB-2:0] == '0;
        st.rest_zero      = rest_reg == '0;
        st.out_free       = !valid_reg || out_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_cmd;
            query_reg <= in_query;
            rest_reg  <= in_query;
            cnt_reg   <= {1'b1, {(LB-1){1'b0}}};
            start_reg <= '0;
            h_reg     <= mmrpl_pkg::HEIGHT_W'(LB - 1);
            ones_reg  <= '0;
        end else if (cmd.step) begin
            rest_reg <= {rest_reg[LB-2:0], 1'b0};
            cnt_reg  <= {1'b0, cnt_reg[LB-1:1]};
            h_reg    <= h_reg - mmrpl_pkg::HEIGHT_W'(1);
            if (rest_reg[LB-1]) begin
                start_reg <= start_reg | cnt_reg;
                ones_reg  <= ones_reg + mmrpl_pkg::ONES_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit != mmrpl_pkg::EMIT_NONE) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.emit)
            mmrpl_pkg::EMIT_ERR: begin
                status_reg <= cmd.err_status;
                first_reg  <= '0;
                count_reg  <= '0;
                height_reg <= '0;
                pos_reg    <= '0;
                last_reg   <= 1'b1;
            end
            mmrpl_pkg::EMIT_PEAK: begin
                status_reg <= mmrpl_pkg::ST_OK;
                first_reg  <= start_reg;
                count_reg  <= cnt_reg;
                height_reg <= h_reg;
                pos_reg    <= peak_pos;
                last_reg   <= rest_reg[LB-2:0] == '0;
            end
            mmrpl_pkg::EMIT_FINAL: begin
                status_reg <= mmrpl_pkg::ST_OK;
                pos_reg    <= query_pos;
                height_reg <= '0;
                last_reg   <= 1'b1;
                if (cmd_reg == mmrpl_pkg::CMD_LEAF_POS) begin
                    first_reg <= query_reg;
                    count_reg <= LB'(1);
                end else begin
                    first_reg <= '0;
                    count_reg <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_first  = first_reg;
    assign out_count  = count_reg;
    assign out_height = height_reg;
    assign out_pos    = pos_reg;
    assign out_last   = last_reg;

endmodule

@@ src/mmr_peak_locator_top.sv @@
// Top level of the Merkle mountain range peak locator: committed leaf count
// register, stream packing, controller and datapath. Uses mmrpl_pkg,
// mmrpl_ctrl and mmrpl_dp.
//
// This block computes where the nodes of a Merkle mountain range sit in a
// flat, append-ordered record store. A request carries a command in s_tuser
// and a leaf count or leaf index in s_tdata. Command 0 returns one result
// per peak, largest first, with the peak's first leaf, leaf count, height
// and record position; command 1 returns the record position of one leaf;
// command 2 returns the total record count. Requests beyond the committed
// leaf count, and the unused command 3, return a single result with invalid
// status; command 0 with a count of zero returns a single result with empty
// status. m_tlast marks the final result of each request. Requests are
// processed one at a time. A rejected or empty request is answered
// straight from the idle state without a scan. A valid request is loaded
// and then scanned one bit position per cycle from the top bit down,
// unless the scan is stalled: for command 0 the scan stops at the lowest
// set bit; commands 1 and 2 scan down to the lowest set bit as well and
// then emit their result. This single-bit scan is shared by all commands,
// and any cycle in which the result register is held by the consumer
// stalls the scan.
// The committed leaf count is written through cfg_wr_en and cfg_wr_data,
// and should only be changed while no request is in flight.
module mmr_peak_locator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: committed leaf count.
    input  logic                               cfg_wr_en,
    input  logic [mmrpl_pkg::LEAF_BITS-1:0]    cfg_wr_data,
    // Request channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mmrpl_pkg::LEAF_BITS-1:0]    s_tdata,  // query_value
    input  logic [mmrpl_pkg::CMD_W-1:0]        s_tuser,  // cmd
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // peak_first_leaf, peak_leaf_count, peak_height, record_position, zero pad
    output logic [mmrpl_pkg::MDATA_W-1:0]      m_tdata,
    output logic [mmrpl_pkg::STATUS_W-1:0]     m_tuser,  // status
    output logic                               m_tlast   // last_result
);

    logic [mmrpl_pkg::LEAF_BITS-1:0] committed_reg;

    mmrpl_pkg::dp_cmd_t    dp_cmd;
    mmrpl_pkg::dp_status_t dp_st;

    logic [mmrpl_pkg::LEAF_BITS-1:0] out_first;
    logic [mmrpl_pkg::LEAF_BITS-1:0] out_count;
    logic [mmrpl_pkg::HEIGHT_W-1:0]  out_height;
    logic [mmrpl_pkg::POS_W-1:0]     out_pos;

    // The committed count resets to an empty store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            committed_reg <= '0;
        end else if (cfg_wr_en) begin
            committed_reg <= cfg_wr_data;
        end
    end

    mmrpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (dp_st),
        .cmd      (dp_cmd)
    );

    mmrpl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tuser),
        .in_query   (s_tdata),
        .committed  (committed_reg),
        .cmd        (dp_cmd),
        .st         (dp_st),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_first  (out_first),
        .out_count  (out_count),
        .out_height (out_height),
        .out_pos    (out_pos),
        .out_last   (m_tlast)
    );

    // Result fields are packed from the lowest bit up, padded to whole bytes.
    assign m_tdata = {{mmrpl_pkg::MPAD_W{1'b0}}, out_pos, out_height, out_count, out_first};

endmodule

@@ tb/mmr_peak_locator_top_tb.sv @@
// Self-checking testbench for mmr_peak_locator_top: directed and random
// requests against an in-bench model of the peak position arithmetic.
// Depends on mmrpl_pkg and mmr_peak_locator_top only.
`timescale 1ns / 1ps

module mmr_peak_locator_top_tb;

    // One result as seen on the master side, fields unpacked.
    typedef struct packed {
        logic [mmrpl_pkg::STATUS_W-1:0]  status;
        logic [mmrpl_pkg::LEAF_BITS-1:0] first_leaf;
        logic [mmrpl_pkg::LEAF_BITS-1:0] span_leaves;
        logic [mmrpl_pkg::HEIGHT_W-1:0]  height;
        logic [mmrpl_pkg::POS_W-1:0]     position;
        logic                            last;
    } locator_result_t;

    // Kinds of rows in the directed script. A known row carries its expected
    // status and record position; the other result fields are zero and last is set.
    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_REQUEST,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [mmrpl_pkg::CMD_W-1:0]     cmd;
        logic [mmrpl_pkg::LEAF_BITS-1:0] value;
        mmrpl_pkg::status_t              status;
        logic [mmrpl_pkg::POS_W-1:0]     position;
    } script_row_t;

    localparam logic [mmrpl_pkg::LEAF_BITS-1:0] ALL_LEAVES = {mmrpl_pkg::LEAF_BITS{1'b1}};
    localparam logic [mmrpl_pkg::LEAF_BITS-1:0] TOP_LEAF   =
        {1'b1, {(mmrpl_pkg::LEAF_BITS-1){1'b0}}};
    localparam logic [mmrpl_pkg::LEAF_BITS-1:0] EVEN_BITS  =
        {(mmrpl_pkg::LEAF_BITS/2){2'b01}};
    localparam logic [mmrpl_pkg::LEAF_BITS-1:0] ODD_BITS   =
        {(mmrpl_pkg::LEAF_BITS/2){2'b10}};

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [mmrpl_pkg::LEAF_BITS-1:0]   cfg_wr_data = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [mmrpl_pkg::LEAF_BITS-1:0]   s_tdata = '0;
    logic [mmrpl_pkg::CMD_W-1:0]       s_tuser = mmrpl_pkg::CMD_PEAKS;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [mmrpl_pkg::MDATA_W-1:0]     m_tdata;
    logic [mmrpl_pkg::STATUS_W-1:0]    m_tuser;
    logic                              m_tlast;

    locator_result_t                   expected_records[$];
    script_row_t                       script[$];
    logic [mmrpl_pkg::LEAF_BITS-1:0]   committed_copy = '0;
    bit                                quiet_flow = 1'b0;
    int                                stall_left = 0;
    int                                mismatches = 0;
    int                                requests_sent = 0;
    int                                results_seen = 0;
    int                                peak_results = 0;

    mmr_peak_locator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: far above the slowest legal run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic expect_record(input locator_result_t r);
        expected_records = {expected_records, r};
    endtask

    task automatic add_row(input script_row_t row);
        script = {script, row};
    endtask

    // Works out the result records of one request from the committed leaf
    // count held in the bench and queues them in order.
    task automatic predict_positions(input logic [mmrpl_pkg::CMD_W-1:0] cmd,
                                     input logic [mmrpl_pkg::LEAF_BITS-1:0] query);
        locator_result_t r;
        logic [63:0]     start;
        logic [63:0]     span;
        logic [63:0]     last_leaf;
        logic [63:0]     rest;
        int              b;
        r = '0;
        r.last = 1'b1;
        r.status = mmrpl_pkg::ST_INVALID;
        last_leaf = {16'd0, query};
        case (cmd)
            mmrpl_pkg::CMD_LEAF_POS: begin
                if (query < committed_copy) begin
                    r.status = mmrpl_pkg::ST_OK;
                    r.first_leaf = query;
                    r.span_leaves = mmrpl_pkg::LEAF_BITS'(1);
                    r.position = mmrpl_pkg::POS_W'(last_leaf * 2 - 64'($countones(last_leaf)));
                end
            end
            mmrpl_pkg::CMD_TOTAL: begin
                if (query <= committed_copy) begin
                    r.status = mmrpl_pkg::ST_OK;
                    r.position = mmrpl_pkg::POS_W'(last_leaf * 2 - 64'($countones(last_leaf)));
                end
            end
            mmrpl_pkg::CMD_PEAKS: begin
                if (query <= committed_copy && query == 0) begin
                    r.status = mmrpl_pkg::ST_EMPTY;
                end else if (query <= committed_copy) begin
                    // One peak per set bit, largest first; the first leaf of
                    // each peak follows the last leaf of the one before.
                    start = 0;
                    rest = {16'd0, query};
                    for (b = mmrpl_pkg::LEAF_BITS - 1; b >= 0; b--) begin
                        if (rest[b]) begin
                            span = 64'd1 << b;
                            last_leaf = start + span - 1;
                            rest[b] = 1'b0;
                            r.status = mmrpl_pkg::ST_OK;
                            r.first_leaf = mmrpl_pkg::LEAF_BITS'(start);
                            r.span_leaves = mmrpl_pkg::LEAF_BITS'(span);
                            r.height = mmrpl_pkg::HEIGHT_W'(b);
                            r.position = mmrpl_pkg::POS_W'(last_leaf * 2
                                         - 64'($countones(last_leaf)) + 64'(b));
                            r.last = (rest == 0);
                            expect_record(r);
                            start = start + span;
                        end
                    end
                    return;
                end
            end
            default: r.status = mmrpl_pkg::ST_INVALID;
        endcase
        expect_record(r);
    endtask

    // Offers one request after a random gap, or none in quiet phases, and queues what it should give,
    // either the typed-in result or the predicted records.
    task automatic send_request(input logic [mmrpl_pkg::CMD_W-1:0] cmd,
                                input logic [mmrpl_pkg::LEAF_BITS-1:0] value,
                                input bit known, input mmrpl_pkg::status_t status,
                                input logic [mmrpl_pkg::POS_W-1:0] position);
        int              gap;
        locator_result_t r;
        gap = quiet_flow ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (known) begin
            r = '0;
            r.status = status;
            r.position = position;
            r.last = 1'b1;
            expect_record(r);
        end else begin
            predict_positions(cmd, value);
        end
        requests_sent++;
    endtask

    // Holds the request channel idle until every queued result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
    endtask

    task automatic write_committed(input logic [mmrpl_pkg::LEAF_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        committed_copy = value;
    endtask

    function automatic script_row_t request_row(
            input logic [mmrpl_pkg::CMD_W-1:0] cmd,
            input logic [mmrpl_pkg::LEAF_BITS-1:0] value);
        return '{ROW_REQUEST, cmd, value, mmrpl_pkg::ST_OK, '0};
    endfunction

    function automatic script_row_t known_row(
            input logic [mmrpl_pkg::CMD_W-1:0] cmd,
            input logic [mmrpl_pkg::LEAF_BITS-1:0] value,
            input mmrpl_pkg::status_t status,
            input logic [mmrpl_pkg::POS_W-1:0] position);
        return '{ROW_KNOWN, cmd, value, status, position};
    endfunction

    function automatic script_row_t config_row(
            input logic [mmrpl_pkg::LEAF_BITS-1:0] value);
        return '{ROW_CONFIG, mmrpl_pkg::CMD_PEAKS, value, mmrpl_pkg::ST_OK, '0};
    endfunction

    function automatic logic [mmrpl_pkg::LEAF_BITS-1:0] random_leaves();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[mmrpl_pkg::LEAF_BITS-1:0];
    endfunction

    // Mostly values inside the committed range, plus the edges around the
    // bound, single powers of two and the odd value from anywhere.
    function automatic logic [mmrpl_pkg::LEAF_BITS-1:0] random_query();
        logic [63:0] span;
        case ($urandom_range(0, 15))
            0: return '0;
            1: return committed_copy;
            2: return committed_copy + 1'b1;
            3: return (committed_copy == 0) ? '0 : committed_copy - 1'b1;
            4: return random_leaves();
            5: return TOP_LEAF >> $urandom_range(0, mmrpl_pkg::LEAF_BITS - 1);
            6: return mmrpl_pkg::LEAF_BITS'($urandom_range(0, 64));
            default: begin
                span = {16'd0, committed_copy} + 1;
                return mmrpl_pkg::LEAF_BITS'({16'd0, random_leaves()} % span);
            end
        endcase
    endfunction

    function automatic logic [mmrpl_pkg::CMD_W-1:0] random_command();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) return mmrpl_pkg::CMD_PEAKS;
        if (pick < 15) return mmrpl_pkg::CMD_LEAF_POS;
        if (pick < 19) return mmrpl_pkg::CMD_TOTAL;
        return mmrpl_pkg::CMD_UNUSED;
    endfunction

    // Result side: after each accepted result the ready line may drop for a
    // freshly drawn random stall; it stays high in quiet phases.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        locator_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            stall_left = quiet_flow ? 0 : $urandom_range(0, 19);
            if (expected_records.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(m_tuser), 64'd0);
            end else begin
                want = expected_records.pop_front();
                if (want.status == mmrpl_pkg::ST_OK && want.span_leaves > 1)
                    peak_results++;
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[mmrpl_pkg::LEAF_BITS-1:0] !== want.first_leaf)
                    report_mismatch("peak_first_leaf",
                                    64'(m_tdata[mmrpl_pkg::LEAF_BITS-1:0]),
                                    64'(want.first_leaf));
                if (m_tdata[mmrpl_pkg::LEAF_BITS +: mmrpl_pkg::LEAF_BITS]
                    !== want.span_leaves)
                    report_mismatch("peak size",
                                    64'(m_tdata[mmrpl_pkg::LEAF_BITS +: mmrpl_pkg::LEAF_BITS]),
                                    64'(want.span_leaves));
                if (m_tdata[2*mmrpl_pkg::LEAF_BITS +: mmrpl_pkg::HEIGHT_W] !== want.height)
                    report_mismatch("peak_height",
                                    64'(m_tdata[2*mmrpl_pkg::LEAF_BITS +: mmrpl_pkg::HEIGHT_W]),
                                    64'(want.height));
                if (m_tdata[2*mmrpl_pkg::LEAF_BITS+mmrpl_pkg::HEIGHT_W +: mmrpl_pkg::POS_W]
                    !== want.position)
                    report_mismatch("record_position",
                                    64'(m_tdata[2*mmrpl_pkg::LEAF_BITS+mmrpl_pkg::HEIGHT_W
                                                +: mmrpl_pkg::POS_W]),
                                    64'(want.position));
                if (m_tlast !== want.last)
                    report_mismatch("last_result", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    initial begin : stimulus
        script_row_t row;
        int          phase;
        int          n;
        int          phase_items;

        // With nothing committed after reset, every query beyond the empty store is refused.
        add_row(known_row(mmrpl_pkg::CMD_LEAF_POS, '0, mmrpl_pkg::ST_INVALID, '0));
        add_row(known_row(mmrpl_pkg::CMD_PEAKS, '0, mmrpl_pkg::ST_EMPTY, '0));
        add_row(known_row(mmrpl_pkg::CMD_TOTAL, '0, mmrpl_pkg::ST_OK, '0));
        add_row(known_row(mmrpl_pkg::CMD_PEAKS, mmrpl_pkg::LEAF_BITS'(1),
                          mmrpl_pkg::ST_INVALID, '0));
        add_row(known_row(mmrpl_pkg::CMD_TOTAL, mmrpl_pkg::LEAF_BITS'(1),
                          mmrpl_pkg::ST_INVALID, '0));
        add_row(known_row(mmrpl_pkg::CMD_UNUSED, ALL_LEAVES, mmrpl_pkg::ST_INVALID, '0));
        // Full store: the largest counts and indexes become legal.
        add_row(config_row(ALL_LEAVES));
        add_row(known_row(mmrpl_pkg::CMD_TOTAL, ALL_LEAVES, mmrpl_pkg::ST_OK,
                          49'h1_FFFF_FFFF_FFCE));
        add_row(known_row(mmrpl_pkg::CMD_LEAF_POS, ALL_LEAVES, mmrpl_pkg::ST_INVALID, '0));
        add_row(request_row(mmrpl_pkg::CMD_PEAKS, ALL_LEAVES));
        add_row(request_row(mmrpl_pkg::CMD_LEAF_POS, ALL_LEAVES - 1'b1));
        add_row(request_row(mmrpl_pkg::CMD_PEAKS, mmrpl_pkg::LEAF_BITS'(1)));
        add_row(known_row(mmrpl_pkg::CMD_TOTAL, TOP_LEAF, mmrpl_pkg::ST_OK,
                          49'h0_FFFF_FFFF_FFFF));
        add_row(request_row(mmrpl_pkg::CMD_PEAKS, TOP_LEAF));
        add_row(request_row(mmrpl_pkg::CMD_PEAKS, EVEN_BITS));
        add_row(request_row(mmrpl_pkg::CMD_PEAKS, ODD_BITS));
        add_row(request_row(mmrpl_pkg::CMD_LEAF_POS, '0));
        add_row(request_row(mmrpl_pkg::CMD_LEAF_POS, ODD_BITS));
        add_row(known_row(mmrpl_pkg::CMD_UNUSED, '0, mmrpl_pkg::ST_INVALID, '0));
        // Small store: the bound sits right between neighbors.
        add_row(config_row(mmrpl_pkg::LEAF_BITS'(5)));
        add_row(request_row(mmrpl_pkg::CMD_PEAKS, mmrpl_pkg::LEAF_BITS'(5)));
        add_row(known_row(mmrpl_pkg::CMD_PEAKS, mmrpl_pkg::LEAF_BITS'(6),
                          mmrpl_pkg::ST_INVALID, '0));
        add_row(known_row(mmrpl_pkg::CMD_LEAF_POS, mmrpl_pkg::LEAF_BITS'(5),
                          mmrpl_pkg::ST_INVALID, '0));
        add_row(request_row(mmrpl_pkg::CMD_LEAF_POS, mmrpl_pkg::LEAF_BITS'(4)));
        add_row(known_row(mmrpl_pkg::CMD_TOTAL, mmrpl_pkg::LEAF_BITS'(5), mmrpl_pkg::ST_OK,
                          mmrpl_pkg::POS_W'(8)));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_CONFIG) begin
                drain_results();
                write_committed(row.value);
            end else begin
                send_request(row.cmd, row.value, row.kind == ROW_KNOWN,
                             row.status, row.position);
            end
        end

        // Random phases, each under its own committed leaf count. The drain
        // before each write also makes the sender wait for every result.
        for (phase = 0; phase < 6; phase++) begin
            drain_results();
            phase_items = 45;
            quiet_flow = (phase == 1 || phase == 5);
            case (phase)
                0: write_committed(ALL_LEAVES);
                1: write_committed(random_leaves());
                2: write_committed(mmrpl_pkg::LEAF_BITS'($urandom_range(1, 40)));
                3: write_committed(TOP_LEAF);
                4: begin
                    write_committed('0);
                    phase_items = 10;
                end
                default: write_committed(random_leaves() >> $urandom_range(0, 40));
            endcase
            for (n = 0; n < phase_items; n++)
                send_request(random_command(), random_query(), 1'b0,
                             mmrpl_pkg::ST_OK, '0);
        end

        drain_results();
        quiet_flow = 1'b0;
        repeat (60) @(posedge aclk);

        $display("Covered %0d requests and %0d results, %0d of them multi-leaf peaks,",
                 requests_sent, results_seen, peak_results);
        $display("under empty, full, small and random committed leaf counts.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/mmrpl_pkg.sv
src/mmrpl_ctrl.sv
src/mmrpl_dp.sv
src/mmr_peak_locator_top.sv
tb/mmr_peak_locator_top_tb.sv
